/* rtl/core/assert_macros.svh */
// Assertion macros shared by the execute unit modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SEB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SEB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/seb_pkg.sv */
// Shared types, opcode constants and helper functions of the stack execute unit.
// Depends on nothing; every other source file but assert_macros.svh imports it.
package seb_pkg;

    localparam int EXPR_DEPTH = 1024;
    localparam int RET_DEPTH  = 1024;
    localparam int EXPR_AW    = $clog2(EXPR_DEPTH);
    localparam int RET_AW     = $clog2(RET_DEPTH);
    localparam int QDEPTH     = 2;
    localparam int DIV_STEPS  = 64;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam logic [5:0] OP_NOP      = 6'd0;
    localparam logic [5:0] OP_PUSH8    = 6'd1;
    localparam logic [5:0] OP_PUSH64   = 6'd4;
    localparam logic [5:0] OP_PUSHD    = 6'd5;
    localparam logic [5:0] OP_EXT_LO   = 6'd6;
    localparam logic [5:0] OP_SEXT_LO  = 6'd12;
    localparam logic [5:0] OP_EXT_HI   = 6'd17;
    localparam logic [5:0] OP_TRN_LO   = 6'd18;
    localparam logic [5:0] OP_TRN_HI   = 6'd23;
    localparam logic [5:0] OP_ALU_LO   = 6'd24;
    localparam logic [5:0] OP_ALU_HI   = 6'd55;
    localparam logic [5:0] OP_DUP      = 6'd56;
    localparam logic [5:0] OP_DROP     = 6'd57;
    localparam logic [5:0] OP_SWAP     = 6'd58;
    localparam logic [5:0] OP_CALL     = 6'd59;
    localparam logic [5:0] OP_CJMP     = 6'd60;
    localparam logic [5:0] OP_RET      = 6'd61;
    localparam logic [5:0] OP_END      = 6'd62;
    localparam logic [5:0] OP_FOREIGN  = 6'd63;

    typedef enum logic [3:0] {
        C_NOP, C_PUSH, C_EXT, C_TRUNC, C_ALU, C_DUP, C_DROP, C_SWAP,
        C_CALL, C_CJMP, C_RET, C_END, C_FOREIGN
    } t_cls;

    typedef enum logic [2:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_LTU, ALU_LTS, ALU_GTU, ALU_GTS
    } t_alu;

    typedef enum logic [1:0] {W8, W16, W32, W64} t_wcode;

    typedef enum logic [2:0] {
        F_OK, F_EXPR_OV, F_EXPR_UF, F_RET_ERR, F_DIV_ZERO, F_UNSUP
    } t_fault;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MUL, S_DIV, S_DONE, S_WR2
    } t_state;

    // One classified instruction as it travels from the front to the back.
    typedef struct packed {
        t_cls        cls;
        t_alu        alu;
        t_wcode      w;
        t_wcode      ext_from;
        t_wcode      ext_to;
        logic        sext;
        logic [63:0] imm;
        logic [31:0] fall;
    } t_dec;

    function automatic logic [63:0] wmask(input t_wcode w);
        case (w)
            W8:      wmask = 64'h0000_0000_0000_00FF;
            W16:     wmask = 64'h0000_0000_0000_FFFF;
            W32:     wmask = 64'h0000_0000_FFFF_FFFF;
            default: wmask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    function automatic logic [63:0] put_low(input logic [63:0] old, input logic [63:0] val,
                                            input t_wcode w);
        put_low = (old & ~wmask(w)) | (val & wmask(w));
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] v, input t_wcode w);
        case (w)
            W8:      sign_ext = {{56{v[7]}}, v[7:0]};
            W16:     sign_ext = {{48{v[15]}}, v[15:0]};
            W32:     sign_ext = {{32{v[31]}}, v[31:0]};
            default: sign_ext = v;
        endcase
    endfunction

endpackage

/* rtl/core/seb_front.sv */
// Front of the execute unit: accepts instruction items and classifies the opcode.
// Depends on seb_pkg; feeds seb_queue.
module seb_front
    import seb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [5:0]  i_func,
    input  logic [63:0] i_immediate,
    input  logic [31:0] i_fallthrough_addr,
    output logic        o_push_valid,
    input  logic        i_push_ready,
    output t_dec        o_push_item
);

    logic r_v;
    t_dec r_d;
    t_dec dec;
    logic [5:0] ext_k;

    always_comb begin
        dec          = '0;
        dec.cls      = C_NOP;
        dec.alu      = t_alu'(3'(6'(i_func - OP_ALU_LO) >> 2));
        dec.w        = t_wcode'(i_func[1:0]);
        dec.imm      = i_immediate;
        dec.fall     = i_fallthrough_addr;
        dec.sext     = (i_func >= OP_SEXT_LO);
        ext_k        = 6'(i_func - OP_EXT_LO);
        if (ext_k >= 6'd6) begin
            ext_k = 6'(ext_k - 6'd6);
        end
        case (ext_k)
            6'd0:    begin dec.ext_from = W8;  dec.ext_to = W16; end
            6'd1:    begin dec.ext_from = W8;  dec.ext_to = W32; end
            6'd2:    begin dec.ext_from = W8;  dec.ext_to = W64; end
            6'd3:    begin dec.ext_from = W16; dec.ext_to = W32; end
            6'd4:    begin dec.ext_from = W16; dec.ext_to = W64; end
            default: begin dec.ext_from = W32; dec.ext_to = W64; end
        endcase
        unique case (i_func) inside
            OP_NOP:                 dec.cls = C_NOP;
            [OP_PUSH8:OP_PUSH64]: begin
                dec.cls = C_PUSH;
                dec.w   = t_wcode'(2'(i_func - OP_PUSH8));
            end
            OP_PUSHD: begin
                dec.cls = C_PUSH;
                dec.w   = W64;
            end
            [OP_EXT_LO:OP_EXT_HI]:  dec.cls = C_EXT;
            [OP_TRN_LO:OP_TRN_HI]:  dec.cls = C_TRUNC;
            [OP_ALU_LO:OP_ALU_HI]:  dec.cls = C_ALU;
            OP_DUP:                 dec.cls = C_DUP;
            OP_DROP:                dec.cls = C_DROP;
            OP_SWAP:                dec.cls = C_SWAP;
            OP_CALL:                dec.cls = C_CALL;
            OP_CJMP:                dec.cls = C_CJMP;
            OP_RET:                 dec.cls = C_RET;
            OP_END:                 dec.cls = C_END;
            default:                dec.cls = C_FOREIGN;
        endcase
    end

    assign o_in_ready   = !r_v || i_push_ready;
    assign o_push_valid = r_v;
    assign o_push_item  = r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_v <= 1'b1;
        end else if (i_push_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_d <= dec;
        end
    end

endmodule

/* rtl/core/seb_queue.sv */
// Short queue of classified items between the front and the back.
// Depends on seb_pkg and assert_macros.svh.
`include "assert_macros.svh"
module seb_queue
    import seb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_dec i_push_item,
    output logic o_pop_valid,
    input  logic i_pop,
    output t_dec o_pop_item
);

    localparam int PW = $clog2(QDEPTH);

    t_dec            r_mem [QDEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != (PW+1)'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : PW'(r_wp + 1'b1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : PW'(r_rp + 1'b1);
            end
            if (push && !pop) begin
                r_cnt <= (PW+1)'(r_cnt + 1'b1);
            end else if (pop && !push) begin
                r_cnt <= (PW+1)'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

    `SEB_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= (PW+1)'(QDEPTH))
    `SEB_ASSERT_NXT(a_cnt_up, push && !pop, r_cnt == (PW+1)'($past(r_cnt) + 1'b1))
    `SEB_ASSERT_NXT(a_cnt_dn, pop && !push, r_cnt == (PW+1)'($past(r_cnt) - 1'b1))

endmodule

/* rtl/core/seb_back.sv */
// Back of the execute unit: stack memories, arithmetic sequencer and result register.
// Depends on seb_pkg and assert_macros.svh; takes items from seb_queue.
`include "assert_macros.svh"
module seb_back
    import seb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop,
    input  t_dec               i_item,
    input  logic [31:0]        i_entry_addr,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_next_addr,
    output logic               o_halted,
    output logic signed [31:0] o_exit_code,
    output logic [2:0]         o_fault
);

    t_state r_state, n_state;

    logic [63:0] r_emem [EXPR_DEPTH];
    logic [31:0] r_rmem [RET_DEPTH];
    logic [63:0] r_rd_a, r_rd_b;
    logic [31:0] r_rd_r;

    logic [EXPR_AW-1:0] r_top, r_hwm, r_top_n, n_top_n;
    logic [RET_AW-1:0]  r_rdep, r_rdep_n, n_rdep_n;
    t_dec               r_it;
    logic               r_va, r_vb;

    logic               r_ov;
    logic [31:0]        r_nx, n_nx, r_onx;
    logic               r_halt, n_halt, r_ohalt;
    logic [31:0]        r_exit, n_exit, r_oexit;
    t_fault             r_fault, n_fault, r_ofault;

    logic               r_we, n_we, r_we2, n_we2, r_rwe, n_rwe;
    logic [EXPR_AW-1:0] r_waddr, n_waddr, r_waddr2, n_waddr2;
    logic [63:0]        r_wdata, n_wdata, r_wdata2, n_wdata2;

    logic [63:0]        r_a_old, r_opa, r_opb, r_acc, r_q, r_rem, r_ub;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;

    logic [EXPR_AW-1:0] addr_a, addr_b, t;
    logic [63:0]        ra, rb, am, bm, sbit, res, v;
    logic               go_mul, go_div, out_free, mem_we;
    logic [EXPR_AW-1:0] mem_waddr;
    logic [63:0]        mem_wdata;
    logic [63:0]        sa, sb, p, acc_n, q_fin;
    logic [31:0]        mx, my;
    logic [64:0]        trial;
    logic [63:0]        rem_n, q_n;

    assign out_free = !r_ov || i_out_ready;
    assign o_pop    = (r_state == S_IDLE) && i_pop_valid;
    assign t        = r_top;
    assign ra       = r_va ? r_rd_a : '0;
    assign rb       = r_vb ? r_rd_b : '0;

    // Read addresses are issued from the queue head while idle.
    always_comb begin
        addr_a = r_top;
        if (i_item.cls == C_PUSH || i_item.cls == C_DUP) begin
            addr_b = EXPR_AW'(r_top + 1'b1);
        end else begin
            addr_b = EXPR_AW'(r_top - 1'b1);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_pop_valid) n_state = S_READ;
            S_READ: begin
                if (go_mul)      n_state = S_MUL;
                else if (go_div) n_state = S_DIV;
                else             n_state = S_DONE;
            end
            S_MUL:   if (r_cnt == CNT_W'(2)) n_state = S_DONE;
            S_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = r_we2 ? S_WR2 : S_IDLE;
            S_WR2:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Execution of the classified item once its operands are read.
    always_comb begin
        am       = rb & wmask(r_it.w);
        bm       = ra & wmask(r_it.w);
        sbit     = ~(wmask(r_it.w) >> 1) & wmask(r_it.w);
        sa       = sign_ext(am, r_it.w);
        sb       = sign_ext(bm, r_it.w);
        res      = '0;
        v        = ra & wmask(r_it.ext_from);
        if (r_it.sext) begin
            v = sign_ext(v, r_it.ext_from);
        end
        case (r_it.alu)
            ALU_ADD: res = am + bm;
            ALU_SUB: res = am - bm;
            ALU_LTU: res = {63'd0, am < bm};
            ALU_LTS: res = {63'd0, (am ^ sbit) < (bm ^ sbit)};
            ALU_GTU: res = {63'd0, am > bm};
            ALU_GTS: res = {63'd0, (am ^ sbit) > (bm ^ sbit)};
            default: res = '0;
        endcase

        go_mul   = 1'b0;
        go_div   = 1'b0;
        n_nx     = r_it.fall;
        n_halt   = 1'b0;
        n_fault  = F_OK;
        n_we     = 1'b0;
        n_we2    = 1'b0;
        n_rwe    = 1'b0;
        n_waddr  = t;
        n_waddr2 = EXPR_AW'(t - 1'b1);
        n_wdata  = '0;
        n_wdata2 = ra;
        n_top_n  = t;
        n_rdep_n = r_rdep;

        unique case (r_it.cls)
            C_PUSH: begin
                if (t == EXPR_AW'(EXPR_DEPTH - 1)) begin
                    n_fault = F_EXPR_OV;
                end else begin
                    n_we    = 1'b1;
                    n_waddr = EXPR_AW'(t + 1'b1);
                    n_wdata = put_low(rb, r_it.imm, r_it.w);
                    n_top_n = EXPR_AW'(t + 1'b1);
                end
            end
            C_EXT: begin
                if (t == '0) begin
                    n_fault = F_EXPR_UF;
                end else begin
                    n_we    = 1'b1;
                    n_wdata = put_low(ra, v, r_it.ext_to);
                end
            end
            C_TRUNC: begin
                if (t == '0) n_fault = F_EXPR_UF;
            end
            C_ALU: begin
                if (t < EXPR_AW'(2)) begin
                    n_fault = F_EXPR_UF;
                end else if (r_it.alu == ALU_DIV && bm == '0) begin
                    n_fault = F_DIV_ZERO;
                end else begin
                    n_we    = 1'b1;
                    n_waddr = EXPR_AW'(t - 1'b1);
                    n_wdata = put_low(rb, res, r_it.w);
                    n_top_n = EXPR_AW'(t - 1'b1);
                    go_mul  = (r_it.alu == ALU_MUL);
                    go_div  = (r_it.alu == ALU_DIV);
                end
            end
            C_DUP: begin
                if (t == '0) begin
                    n_fault = F_EXPR_UF;
                end else if (t == EXPR_AW'(EXPR_DEPTH - 1)) begin
                    n_fault = F_EXPR_OV;
                end else begin
                    n_we    = 1'b1;
                    n_waddr = EXPR_AW'(t + 1'b1);
                    n_wdata = ra;
                    n_top_n = EXPR_AW'(t + 1'b1);
                end
            end
            C_DROP: begin
                if (t == '0) n_fault = F_EXPR_UF;
                else         n_top_n = EXPR_AW'(t - 1'b1);
            end
            C_SWAP: begin
                if (t < EXPR_AW'(2)) begin
                    n_fault = F_EXPR_UF;
                end else begin
                    n_we    = 1'b1;
                    n_wdata = rb;
                    n_we2   = 1'b1;
                end
            end
            C_CALL: begin
                if (r_rdep == RET_AW'(RET_DEPTH - 1)) begin
                    n_fault = F_RET_ERR;
                end else begin
                    n_rwe    = 1'b1;
                    n_rdep_n = RET_AW'(r_rdep + 1'b1);
                    n_nx     = r_it.imm[31:0];
                end
            end
            C_CJMP: begin
                if (t == '0) begin
                    n_fault = F_EXPR_UF;
                end else begin
                    if (ra[31:0] != '0) n_nx = r_it.imm[31:0];
                    n_top_n = EXPR_AW'(t - 1'b1);
                end
            end
            C_RET: begin
                if (r_rdep == '0) begin
                    n_halt = 1'b1;
                end else begin
                    n_nx     = r_rd_r;
                    n_rdep_n = RET_AW'(r_rdep - 1'b1);
                end
            end
            C_END:   n_halt = 1'b1;
            C_FOREIGN: n_fault = F_UNSUP;
            default: ;
        endcase
        if (n_halt) begin
            n_nx = i_entry_addr;
        end
        n_exit = n_halt ? ra[31:0] : '0;
    end

    // Shared 32x32 multiplier for the three partial products of the low word.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin mx = r_opa[31:0];  my = r_opb[31:0];  end
            2'd1:    begin mx = r_opa[31:0];  my = r_opb[63:32]; end
            default: begin mx = r_opa[63:32]; my = r_opb[31:0];  end
        endcase
        p     = {32'd0, mx} * {32'd0, my};
        acc_n = (r_cnt == '0) ? p : r_acc + {p[31:0], 32'd0};
    end

    // One quotient bit per cycle of the restoring divider.
    always_comb begin
        trial = {r_rem, r_q[63]};
        if (trial >= {1'b0, r_ub}) begin
            rem_n = 64'(trial - {1'b0, r_ub});
            q_n   = {r_q[62:0], 1'b1};
        end else begin
            rem_n = trial[63:0];
            q_n   = {r_q[62:0], 1'b0};
        end
        q_fin = r_neg ? 64'(64'd0 - q_n) : q_n;
    end

    assign mem_we    = (r_state == S_WR2) || (r_state == S_DONE && out_free && r_we);
    assign mem_waddr = (r_state == S_WR2) ? r_waddr2 : r_waddr;
    assign mem_wdata = (r_state == S_WR2) ? r_wdata2 : r_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_emem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_DONE && out_free && r_rwe) begin
            r_rmem[r_rdep_n] <= r_it.fall;
        end
        r_rd_a <= r_emem[addr_a];
        r_rd_b <= r_emem[addr_b];
        r_rd_r <= r_rmem[r_rdep];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= '0;
            r_hwm   <= '0;
            r_rdep  <= '0;
            r_ov    <= 1'b0;
            r_we    <= 1'b0;
            r_we2   <= 1'b0;
            r_rwe   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ) begin
                r_we  <= n_we;
                r_we2 <= n_we2;
                r_rwe <= n_rwe;
            end
            if (r_state == S_DONE && out_free) begin
                r_ov   <= 1'b1;
                r_top  <= r_top_n;
                r_rdep <= r_rdep_n;
                if (r_we && r_waddr > r_hwm) begin
                    r_hwm <= r_waddr;
                end
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_it <= i_item;
            r_va <= (addr_a != '0) && (addr_a <= r_hwm);
            r_vb <= (addr_b != '0) && (addr_b <= r_hwm);
        end
        if (r_state == S_READ) begin
            r_nx     <= n_nx;
            r_halt   <= n_halt;
            r_exit   <= n_exit;
            r_fault  <= n_fault;
            r_waddr  <= n_waddr;
            r_waddr2 <= n_waddr2;
            r_wdata  <= n_wdata;
            r_wdata2 <= n_wdata2;
            r_top_n  <= n_top_n;
            r_rdep_n <= n_rdep_n;
            r_a_old  <= rb;
            r_opa    <= am;
            r_opb    <= bm;
            r_cnt    <= '0;
            r_q      <= sa[63] ? 64'(64'd0 - sa) : sa;
            r_ub     <= sb[63] ? 64'(64'd0 - sb) : sb;
            r_rem    <= '0;
            r_neg    <= sa[63] ^ sb[63];
        end
        if (r_state == S_MUL) begin
            r_acc <= acc_n;
            r_cnt <= CNT_W'(r_cnt + 1'b1);
            if (r_cnt == CNT_W'(2)) begin
                r_wdata <= put_low(r_a_old, acc_n, r_it.w);
            end
        end
        if (r_state == S_DIV) begin
            r_q   <= q_n;
            r_rem <= rem_n;
            r_cnt <= CNT_W'(r_cnt + 1'b1);
            if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                r_wdata <= put_low(r_a_old, q_fin, r_it.w);
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_onx    <= r_nx;
            r_ohalt  <= r_halt;
            r_oexit  <= r_exit;
            r_ofault <= r_fault;
        end
    end

    assign o_out_valid = r_ov;
    assign o_next_addr = r_onx;
    assign o_halted    = r_ohalt;
    assign o_exit_code = $signed(r_oexit);
    assign o_fault     = r_ofault;

    `SEB_ASSERT_IMP(a_top_in_hwm, 1'b1, r_top <= r_hwm)
    `SEB_ASSERT_NXT(a_load_out, r_state == S_DONE && out_free, r_ov)
    `SEB_ASSERT_IMP(a_pop_idle, o_pop, r_state == S_IDLE && r_state != S_WR2)
    `SEB_ASSERT_NXT(a_mul_cnt, r_state == S_MUL && r_cnt != CNT_W'(2), r_state == S_MUL)

endmodule

/* rtl/core/stack_bytecode_execute_unit.sv */
// Top level of the stack bytecode execute unit.
// Depends on seb_pkg, seb_front, seb_queue and seb_back.
//
// This unit executes one decoded instruction of a 64-bit stack machine per input item
// and returns one result item per input: the next address, a halt flag with exit code,
// and a fault code. Plain stack, branch and call items pass through the front register,
// then the read, execute and write-back steps on the single-write, two-read expression
// memory in the back; a swap adds a further write step for its second write.
// Multiplies add a multiply step, since the low 64 bits are built from three 32x32
// partial products on one shared multiplier. Divides add a divide step in the restoring
// divider, one quotient bit per cycle. The front keeps accepting items into a two-entry
// queue while the back works. The back executes the next item while the last result
// still waits in the output register, and writes it back once that register is free.
// No clearing pass follows reset: a high water mark of written expression entries makes
// unwritten entries read as zero. The entry address register is written through the
// configuration channel, which is always ready; write it only while the unit is idle.
module stack_bytecode_execute_unit
    import seb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [5:0]         i_func,
    input  logic [63:0]        i_immediate,
    input  logic [31:0]        i_fallthrough_addr,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_next_addr,
    output logic               o_halted,
    output logic signed [31:0] o_exit_code,
    output logic [2:0]         o_fault
);

    logic [31:0] r_entry;
    logic        push_valid, push_ready, pop_valid, pop;
    t_dec        push_item, pop_item;

    assign o_cfg_ready = 1'b1;

    // The entry address is also reported as next address on a halt.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_cfg_valid) begin
            r_entry <= i_cfg_data;
        end
    end

    seb_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_func             (i_func),
        .i_immediate        (i_immediate),
        .i_fallthrough_addr (i_fallthrough_addr),
        .o_push_valid       (push_valid),
        .i_push_ready       (push_ready),
        .o_push_item        (push_item)
    );

    seb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_item   (pop_item)
    );

    seb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (pop_valid),
        .o_pop        (pop),
        .i_item       (pop_item),
        .i_entry_addr (r_entry),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_next_addr  (o_next_addr),
        .o_halted     (o_halted),
        .o_exit_code  (o_exit_code),
        .o_fault      (o_fault)
    );

endmodule

/* test/stack_bytecode_execute_unit_tb.sv */
// Testbench of the stack bytecode execute unit: directed items, stack-depth bursts and
// random instruction streams, checked against an in-bench predictor of the machine state.
// Depends on seb_pkg and stack_bytecode_execute_unit.
module stack_bytecode_execute_unit_tb;
    import seb_pkg::*;

    // Opcodes that the package does not name on its own.
    localparam logic [5:0] OP_PUSH16 = 6'd2;
    localparam logic [5:0] OP_PUSH32 = 6'd3;

    // Depth to which the calm bursts build both stacks in their loops.
    localparam int BURST_DEPTH = 32;

    typedef struct {
        logic [31:0] next_addr;
        logic        halted;
        logic [31:0] exit_code;
        logic [2:0]  fault;
    } t_outcome;

    // Mirror of the machine: both stacks, the entry register and the results still owed.
    class exec_scoreboard;
        logic [63:0] estk[EXPR_DEPTH];
        logic [31:0] rstk[RET_DEPTH];
        int          top;
        int          rdepth;
        logic [31:0] entry;
        t_outcome    owed[$];
        int          errors;

        function new();
            foreach (estk[i]) estk[i] = '0;
            foreach (rstk[i]) rstk[i] = '0;
            top = 0;
            rdepth = 0;
            entry = '0;
            errors = 0;
        endfunction

        function logic [63:0] mask_of(int w);
            return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        endfunction

        function logic [63:0] sext_of(logic [63:0] v, int w);
            logic [63:0] s;
            s = 64'd1 << (w - 1);
            return ((v & mask_of(w)) ^ s) - s;
        endfunction

        function logic [63:0] merge_low(logic [63:0] old, logic [63:0] v, int w);
            return (old & ~mask_of(w)) | (v & mask_of(w));
        endfunction

        // Executes one accepted instruction and queues the result it must produce.
        function void note_item(logic [5:0] op, logic [63:0] imm, logic [31:0] fall);
            int       w, k, from_w, to_w;
            logic [63:0] m, a, b, r, sa, sbv, ua, ub, q, x;
            t_alu     grp;
            t_outcome o;
            o.next_addr = fall;
            o.halted = 1'b0;
            o.exit_code = '0;
            o.fault = F_OK;
            if (op >= OP_PUSH8 && op <= OP_PUSHD) begin
                if (top >= EXPR_DEPTH - 1) begin
                    o.fault = F_EXPR_OV;
                end else begin
                    w = (op == OP_PUSHD) ? 64 : (8 << (op - OP_PUSH8));
                    top++;
                    estk[top] = merge_low(estk[top], imm, w);
                end
            end else if (op >= OP_EXT_LO && op <= OP_TRN_HI) begin
                if (top < 1) begin
                    o.fault = F_EXPR_UF;
                end else if (op <= OP_EXT_HI) begin
                    // Truncations keep the entry as it is; only extensions write.
                    k = (op - OP_EXT_LO) % 6;
                    from_w = (k < 3) ? 8 : (k < 5) ? 16 : 32;
                    to_w = (k == 0) ? 16 : (k == 1 || k == 3) ? 32 : 64;
                    x = estk[top] & mask_of(from_w);
                    if (op >= OP_SEXT_LO) x = sext_of(x, from_w);
                    estk[top] = merge_low(estk[top], x, to_w);
                end
            end else if (op >= OP_ALU_LO && op <= OP_ALU_HI) begin
                if (top < 2) begin
                    o.fault = F_EXPR_UF;
                end else begin
                    w = 8 << op[1:0];
                    grp = t_alu'((op - OP_ALU_LO) >> 2);
                    m = mask_of(w);
                    a = estk[top-1] & m;
                    b = estk[top] & m;
                    x = 64'd1 << (w - 1);
                    r = '0;
                    case (grp)
                        ALU_ADD: r = a + b;
                        ALU_SUB: r = a - b;
                        ALU_MUL: r = a * b;
                        ALU_DIV: begin
                            if (b == 0) begin
                                o.fault = F_DIV_ZERO;
                            end else begin
                                sa = sext_of(a, w);
                                sbv = sext_of(b, w);
                                ua = sa[63] ? -sa : sa;
                                ub = sbv[63] ? -sbv : sbv;
                                q = ua / ub;
                                r = (sa[63] != sbv[63]) ? -q : q;
                            end
                        end
                        ALU_LTU: r = {63'd0, a < b};
                        ALU_LTS: r = {63'd0, (a ^ x) < (b ^ x)};
                        ALU_GTU: r = {63'd0, a > b};
                        default: r = {63'd0, (a ^ x) > (b ^ x)};
                    endcase
                    if (o.fault == F_OK) begin
                        estk[top-1] = merge_low(estk[top-1], r, w);
                        top--;
                    end
                end
            end else if (op == OP_DUP) begin
                if (top < 1) o.fault = F_EXPR_UF;
                else if (top >= EXPR_DEPTH - 1) o.fault = F_EXPR_OV;
                else begin
                    estk[top+1] = estk[top];
                    top++;
                end
            end else if (op == OP_DROP) begin
                if (top < 1) o.fault = F_EXPR_UF;
                else top--;
            end else if (op == OP_SWAP) begin
                if (top < 2) o.fault = F_EXPR_UF;
                else begin
                    x = estk[top];
                    estk[top] = estk[top-1];
                    estk[top-1] = x;
                end
            end else if (op == OP_CALL) begin
                if (rdepth >= RET_DEPTH - 1) o.fault = F_RET_ERR;
                else begin
                    rdepth++;
                    rstk[rdepth] = fall;
                    o.next_addr = imm[31:0];
                end
            end else if (op == OP_CJMP) begin
                if (top < 1) o.fault = F_EXPR_UF;
                else begin
                    if (estk[top][31:0] != 0) o.next_addr = imm[31:0];
                    top--;
                end
            end else if (op == OP_RET) begin
                if (rdepth == 0) o.halted = 1'b1;
                else begin
                    o.next_addr = rstk[rdepth];
                    rdepth--;
                end
            end else if (op == OP_END) begin
                o.halted = 1'b1;
            end else if (op == OP_FOREIGN) begin
                o.fault = F_UNSUP;
            end
            if (o.fault != F_OK) o.next_addr = fall;
            if (o.halted) begin
                o.next_addr = entry;
                o.exit_code = estk[top][31:0];
            end
            owed.push_back(o);
        endfunction

        function void check_result(logic [31:0] na, logic h, logic [31:0] ec, logic [2:0] f);
            t_outcome o;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: next=%h halted=%b", na, h);
                return;
            end
            o = owed.pop_front();
            if (na !== o.next_addr || h !== o.halted || ec !== o.exit_code || f !== o.fault)
                begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: next %h/%h halted %b/%b exit %h/%h fault %0d/%0d",
                             o.next_addr, na, o.halted, h, o.exit_code, ec, o.fault, f);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [5:0]         i_func;
    logic [63:0]        i_immediate;
    logic [31:0]        i_fallthrough_addr;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [31:0]        o_next_addr;
    logic               o_halted;
    logic signed [31:0] o_exit_code;
    logic [2:0]         o_fault;

    exec_scoreboard sb;
    bit             calm;      // When set, neither side idles.
    int             out_wait;

    stack_bytecode_execute_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_func(i_func),
        .i_immediate(i_immediate), .i_fallthrough_addr(i_fallthrough_addr),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_next_addr(o_next_addr),
        .o_halted(o_halted), .o_exit_code(o_exit_code), .o_fault(o_fault)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Results are taken at the edge, where outputs still show the values from before it.
    // After each taken item the receiver may stall for a random number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_next_addr, o_halted, o_exit_code, o_fault);
                out_wait = calm ? 0 : $urandom_range(0, 9);
                if (out_wait > 0) i_out_ready <= 1'b0;
            end else if (!i_out_ready) begin
                if (out_wait <= 1) i_out_ready <= 1'b1;
                out_wait--;
            end
        end
    end

    // Sends one item after a random gap. A gap of zero keeps valid high across items,
    // so valid gets only one assignment in the step in which the previous item went in.
    task automatic send_item(logic [5:0] op, logic [63:0] imm, logic [31:0] fall);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= op;
        i_immediate <= imm;
        i_fallthrough_addr <= fall;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(op, imm, fall);
    endtask

    // Waits until every owed result has come back, then lets the back end settle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_entry(logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.entry = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            2: return 64'd1;
            3: return {32'd0, 32'h8000_0000};
            4: return 64'h8000_0000_0000_0000;
            5: return {$urandom_range(0, 1) ? 48'hFFFF_FFFF_FFFF : 48'd0,
                       $urandom_range(0, 1) ? 16'h8000 : 16'h0080};
            6: return {56'd0, 8'($urandom_range(0, 3))};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly well-formed programs: keep a few operands live, balance calls and returns,
    // and mix in ends, faults and arbitrary tokens now and then.
    function automatic logic [5:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 6'($urandom_range(0, 63));
        if (sb.top < 3 && r < 60) return 6'($urandom_range(OP_PUSH8, OP_PUSHD));
        if (sb.top > 12 && r < 50) return OP_DROP;
        if (r < 22) return 6'($urandom_range(OP_PUSH8, OP_PUSHD));
        if (r < 32) return 6'($urandom_range(OP_EXT_LO, OP_TRN_HI));
        if (r < 70) return 6'($urandom_range(OP_ALU_LO, OP_ALU_HI));
        if (r < 74) return OP_DUP;
        if (r < 77) return OP_DROP;
        if (r < 81) return OP_SWAP;
        if (r < 86) return (sb.rdepth < 6) ? OP_CALL : OP_RET;
        if (r < 91) return OP_RET;
        if (r < 95) return OP_CJMP;
        if (r < 97) return OP_END;
        return (r == 97) ? OP_NOP : OP_FOREIGN;
    endfunction

    task automatic random_run(int n);
        repeat (n) send_item(pick_op(), pick_value(), $urandom);
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        out_wait = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_func = OP_NOP;
        i_immediate = '0;
        i_fallthrough_addr = '0;
        i_out_ready = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_entry(32'h0000_0000);
        // Directed: empty-stack halts, underflow, pushes at every width, an overflow case
        // of signed division, division by zero, extensions and control flow.
        send_item(OP_RET, '1, 32'hFFFF_FFFF);
        send_item(OP_END, '0, 32'h0);
        send_item(OP_DROP, '0, 32'h10);
        send_item(OP_PUSHD, 64'h8000_0000_0000_0000, 32'h14);
        send_item(OP_ALU_LO + 6'd3, '0, 32'h18);
        send_item(OP_PUSHD, '1, 32'h1C);
        send_item(OP_ALU_LO + 6'd15, '0, 32'h20);
        send_item(OP_PUSH8, 64'h80, 32'h24);
        send_item(OP_PUSH16, 64'hFFFF_FFFF_FFFF_0000, 32'h28);
        send_item(OP_ALU_LO + 6'd12, '0, 32'h2C);
        send_item(OP_PUSH32, 64'h8000_0000, 32'h30);
        send_item(OP_SEXT_LO + 6'd5, '0, 32'h34);
        send_item(OP_EXT_LO, '0, 32'h38);
        send_item(OP_TRN_LO, '0, 32'h3C);
        send_item(OP_DUP, '0, 32'h40);
        send_item(OP_SWAP, '0, 32'h44);
        send_item(OP_ALU_LO + 6'd22, '0, 32'h48);
        send_item(OP_CALL, 64'hFFFF_FFFF_FFFF_FFFF, 32'h4C);
        send_item(OP_CJMP, 64'h1234_5678_9ABC_DEF0, 32'h50);
        send_item(OP_RET, '0, 32'h54);
        send_item(OP_NOP, '1, 32'h58);
        send_item(OP_FOREIGN, '1, 32'h5C);
        send_item(OP_PUSH64, 64'h0000_0001_0000_0000, 32'h60);
        send_item(OP_CJMP, 64'hAAAA, 32'h64);
        send_item(OP_END, '0, 32'h68);
        settle();

        write_entry(32'hFFFF_FFFF);
        random_run(200);
        settle();

        // Stack bursts without idling: build the expression stack up, empty it past its
        // bottom, then do the same with the return stack.
        calm = 1'b1;
        while (sb.top < BURST_DEPTH) send_item(OP_PUSH64, {$urandom, $urandom}, $urandom);
        send_item(OP_PUSH8, '1, $urandom);
        send_item(OP_DUP, '0, $urandom);
        while (sb.top > 0) send_item(OP_DROP, '0, $urandom);
        send_item(OP_DROP, '0, $urandom);
        while (sb.rdepth < BURST_DEPTH) send_item(OP_CALL, {$urandom, $urandom}, $urandom);
        send_item(OP_CALL, '0, $urandom);
        while (sb.rdepth > 0) send_item(OP_RET, '0, $urandom);
        send_item(OP_RET, '0, $urandom);
        random_run(60);
        settle();

        calm = 1'b0;
        write_entry($urandom);
        random_run(130);
        settle();

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("[stack_bytecode_execute_unit] OK");
        end else begin
            $display("[stack_bytecode_execute_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #(8 * 1000000);
        $display("[stack_bytecode_execute_unit] ERROR");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/seb_pkg.sv
rtl/core/seb_front.sv
rtl/core/seb_queue.sv
rtl/core/seb_back.sv
rtl/core/stack_bytecode_execute_unit.sv
test/stack_bytecode_execute_unit_tb.sv
